FILE: src/bads_pkg.sv
// ----------------------------------------------------------------------------
// Block average downscaler package
// Shared constants and types for the 16x16 block average downscaler.
// ----------------------------------------------------------------------------
package bads_pkg;

  localparam int GRID_SIZE     = 16;
  localparam int GRID_BITS     = $clog2(GRID_SIZE);
  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_BITS      = 13;
  localparam int POS_BITS      = 12;
  localparam int SUM_BITS      = 20;
  localparam int DEN_BITS      = 9;
  localparam int REM_BITS      = 10;
  localparam int CNT_BITS      = 5;

  localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNEL_SELECT = 2'd2;

  localparam logic [1:0] CHAN_RED   = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_BLUE  = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SDIV = 7'b0000010,
    S_SWR  = 7'b0000100,
    S_BRD  = 7'b0001000,
    S_BLD  = 7'b0010000,
    S_BDIV = 7'b0100000,
    S_BOUT = 7'b1000000
  } state_t;

endpackage

FILE: src/block_average_downscale_16x16_top.sv
// ----------------------------------------------------------------------------
// Block average downscaler, 16x16 grid
// Reduces one color channel of a raster image to a 16x16 grid of block means.
// ----------------------------------------------------------------------------
// One pixel is taken per transfer. A pixel that closes no row segment leaves
// the block idle. A pixel that closes a segment stalls the input through the
// shared one-bit-per-cycle divider and the read, modify and write of the
// column accumulator memory. A pixel that closes a band then emits 16 cells,
// each through the divider and held by any output stall. The accumulators
// live in a 16-entry memory with a registered read, whose entries read as
// zero after reset or after their band is emitted.
module block_average_downscale_16x16_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    red_sample,
  input  logic [7:0]                    green_sample,
  input  logic [7:0]                    blue_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    cell_value,
  output logic [3:0]                    cell_column,
  output logic [3:0]                    cell_row,
  output logic                          band_last,
  output logic                          frame_last,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [bads_pkg::DIM_BITS-1:0] cfg_data
);
  import bads_pkg::*;

  state_t state;
  logic [DIM_BITS-1:0]  image_width, image_height;
  logic [1:0]           channel_select;
  logic [POS_BITS-1:0]  column_position, row_position;
  logic [SUM_BITS-1:0]  segment_sum;
  logic [GRID_BITS-1:0] segment_index, band_index;

  logic [SUM_BITS-1:0]  acc_mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] acc_valid;
  logic [SUM_BITS-1:0]  rd_data;
  logic [GRID_BITS-1:0] rd_addr;

  logic [GRID_BITS-1:0] seg_idx_q, emit_row, col_cnt;
  logic                 row_end_q, band_end_q, frame_end_q;
  logic [DEN_BITS-1:0]  band_div;

  logic [REM_BITS-1:0]  div_rem;
  logic [SUM_BITS-1:0]  div_q;
  logic [DEN_BITS-1:0]  div_den;
  logic [CNT_BITS-1:0]  div_cnt;

  logic [DIM_BITS-1:0]  w, h;
  logic [DEN_BITS-1:0]  seg_w, band_h, seg_div, band_div_now;
  logic [7:0]           sample;
  logic [SUM_BITS-1:0]  sum_now;
  logic [DIM_BITS:0]    col_inc, row_inc;
  logic [DIM_BITS:0]    seg_bound, band_bound;
  logic                 row_end, last_seg, seg_end, frame_end, last_band, band_end;
  logic                 accept;
  logic [REM_BITS:0]    rem_s;
  logic                 ge;
  logic [SUM_BITS-1:0]  acc_old;

  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
    if (v < DIM_BITS'(GRID_SIZE)) return DIM_BITS'(GRID_SIZE);
    if (v > DIM_BITS'(MAX_DIMENSION)) return DIM_BITS'(MAX_DIMENSION);
    return v;
  endfunction

  always_comb begin
    w = clamp_dim(image_width);
    h = clamp_dim(image_height);
    seg_w = DEN_BITS'(w >> GRID_BITS);
    band_h = DEN_BITS'(h >> GRID_BITS);
    case (channel_select)
      CHAN_RED:   sample = red_sample;
      CHAN_GREEN: sample = green_sample;
      CHAN_BLUE:  sample = blue_sample;
      default:    sample = 8'd0;
    endcase
    sum_now = segment_sum + SUM_BITS'(sample);
    col_inc = (DIM_BITS+1)'(column_position) + 1'b1;
    row_inc = (DIM_BITS+1)'(row_position) + 1'b1;
    row_end = col_inc >= (DIM_BITS+1)'(w);
    last_seg = segment_index == GRID_BITS'(GRID_SIZE - 1);
    seg_bound = (DIM_BITS+1)'({1'b0, segment_index} + 1'b1) * (DIM_BITS+1)'(seg_w);
    seg_end = row_end || (!last_seg && col_inc >= seg_bound);
    seg_div = last_seg ? seg_w + DEN_BITS'(w[GRID_BITS-1:0]) : seg_w;
    frame_end = row_inc >= (DIM_BITS+1)'(h);
    last_band = band_index == GRID_BITS'(GRID_SIZE - 1);
    band_bound = (DIM_BITS+1)'({1'b0, band_index} + 1'b1) * (DIM_BITS+1)'(band_h);
    band_end = frame_end || (!last_band && row_inc >= band_bound);
    band_div_now = last_band ? band_h + DEN_BITS'(h[GRID_BITS-1:0]) : band_h;
    rem_s = {div_rem, div_q[SUM_BITS-1]};
    ge = rem_s >= (REM_BITS+1)'(div_den);
    acc_old = acc_valid[seg_idx_q] ? rd_data : '0;
  end

  assign in_stall = state != S_IDLE;
  assign accept = in_valid && !in_stall;
  assign rd_addr = (state == S_IDLE) ? segment_index :
                   ((state == S_SDIV || state == S_SWR) ? seg_idx_q : col_cnt);

  assign out_valid = state == S_BOUT;
  assign cell_value = div_q[7:0];
  assign cell_column = col_cnt;
  assign cell_row = emit_row;
  assign band_last = col_cnt == GRID_BITS'(GRID_SIZE - 1);
  assign frame_last = band_last && frame_end_q;

  always_ff @(posedge clk) begin
    rd_data <= acc_mem[rd_addr];
    if (state == S_SWR) begin
      acc_mem[seg_idx_q] <= acc_old + div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SDIV || state == S_BDIV) begin
      div_rem <= ge ? REM_BITS'(rem_s - (REM_BITS+1)'(div_den)) : REM_BITS'(rem_s);
      div_q <= {div_q[SUM_BITS-2:0], ge};
    end else if (accept) begin
      div_rem <= '0;
      div_q <= sum_now;
      div_den <= seg_div;
    end else if (state == S_BLD) begin
      div_rem <= '0;
      div_q <= acc_valid[col_cnt] ? rd_data : '0;
      div_den <= band_div;
    end
    if (accept) begin
      seg_idx_q <= segment_index;
      row_end_q <= row_end;
      band_end_q <= band_end;
      frame_end_q <= frame_end;
      emit_row <= band_index;
      band_div <= band_div_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      image_width <= DIM_BITS'(16);
      image_height <= DIM_BITS'(16);
      channel_select <= CHAN_RED;
      column_position <= '0;
      row_position <= '0;
      segment_sum <= '0;
      segment_index <= '0;
      band_index <= '0;
      acc_valid <= '0;
      col_cnt <= '0;
      div_cnt <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:    image_width <= cfg_data;
          REG_IMAGE_HEIGHT:   image_height <= cfg_data;
          REG_CHANNEL_SELECT: channel_select <= cfg_data[1:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            segment_sum <= seg_end ? '0 : sum_now;
            if (row_end) begin
              column_position <= '0;
              segment_index <= '0;
              row_position <= frame_end ? '0 : POS_BITS'(row_inc);
              if (band_end) begin
                if (frame_end) band_index <= '0;
                else if (!last_band) band_index <= band_index + 1'b1;
              end
            end else begin
              column_position <= POS_BITS'(col_inc);
              if (seg_end && !last_seg) segment_index <= segment_index + 1'b1;
            end
            if (seg_end) begin
              div_cnt <= '0;
              state <= S_SDIV;
            end
          end
        end
        S_SDIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_BITS'(SUM_BITS - 1)) state <= S_SWR;
        end
        S_SWR: begin
          acc_valid[seg_idx_q] <= 1'b1;
          col_cnt <= '0;
          state <= (row_end_q && band_end_q) ? S_BRD : S_IDLE;
        end
        S_BRD: state <= S_BLD;
        S_BLD: begin
          div_cnt <= '0;
          state <= S_BDIV;
        end
        S_BDIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == CNT_BITS'(SUM_BITS - 1)) state <= S_BOUT;
        end
        S_BOUT: begin
          if (!out_stall) begin
            acc_valid[col_cnt] <= 1'b0;
            if (col_cnt == GRID_BITS'(GRID_SIZE - 1)) begin
              state <= S_IDLE;
            end else begin
              col_cnt <= col_cnt + 1'b1;
              state <= S_BRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/bads_checker.sv
// ----------------------------------------------------------------------------
// Block average downscaler checker
// Port-level properties of the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module bads_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] cell_value,
  input logic [3:0] cell_column,
  input logic       band_last,
  input logic       frame_last
);

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while a cell is pending");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> band_last && cell_column == 4'd15)
    else $error("frame end flagged off the last band cell");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("cell shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(cell_value) && $stable(cell_column))
    else $error("stalled cell changed");

endmodule

bind block_average_downscale_16x16_top bads_checker u_bads_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .cell_value(cell_value), .cell_column(cell_column),
  .band_last(band_last), .frame_last(frame_last)
);
